>>> sv/kdt_pkg.sv
// Package for the keyed device table: sizes, op and status codes, item types.
`timescale 1ns / 1ps

package kdt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_ISOPEN = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_GETPAR = 3'd4;
  localparam logic [2:0] OP_SETPAR = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        serial;
    logic signed [31:0] device_id;
    logic signed [31:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  // One table slot as held in the RAM
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] id;
    logic [31:0] par;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } kdt_state_t;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic commit;
  } kdt_cmd_t;

  typedef struct packed {
    logic             scan_done;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } kdt_sts_t;

endpackage

>>> sv/kdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/kdt_ctrl.sv
// Controller state machine: accept, scan the table, commit the result.
`timescale 1ns / 1ps

module kdt_ctrl import kdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kdt_sts_t sts,
  output kdt_cmd_t cmd
);

  kdt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/kdt_datapath.sv
// Datapath: table RAM, scan pointers, match capture, result register.
`timescale 1ns / 1ps

module kdt_datapath import kdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  input  kdt_cmd_t  cmd,
  output kdt_sts_t  sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t         item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] wr_idx_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [31:0]      hit_id_r;
  logic [31:0]      hit_par_r;
  logic [31:0]      def_par_r;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  logic             more;
  logic             issue;
  logic             key_hit;
  logic             full;
  entry_t           rd_q;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;

  kdt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rd_q)
  );

  assign more    = rd_idx_r < count_r;
  assign issue   = cmd.scan_en && more;
  assign key_hit = pend_r && (rd_q.key == item_r.serial);
  assign full    = count_r == CNT_W'(TABLE_DEPTH);

  assign sts.scan_done = !more && !pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.count     = count_r;

  // Write port: compaction during remove, else the final add or setpar
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.scan_en && pend_r && !key_hit && item_r.op == OP_REMOVE) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx_r[IDX_W-1:0];
      ram_wdata = rd_q;
    end else if (cmd.commit) begin
      case (item_r.op)
        OP_ADD: begin
          ram_we    = !full;
          ram_waddr = count_r[IDX_W-1:0];
          ram_wdata = '{key: item_r.serial, id: item_r.device_id, par: def_par_r};
        end
        OP_SETPAR: begin
          ram_we    = found_r;
          ram_waddr = hit_idx_r;
          ram_wdata = '{key: item_r.serial, id: hit_id_r, par: item_r.param_value};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt    = count_r;
    out_data_nxt = '{found: found_r, value: '0, status: ST_OK};
    case (item_r.op)
      OP_ADD: begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: count_nxt = wr_idx_r;
      OP_ISOPEN: out_data_nxt.value = {31'd0, found_r};
      OP_GET:    out_data_nxt.value = found_r ? hit_id_r : '1;
      OP_GETPAR: begin
        out_data_nxt.value  = found_r ? hit_par_r : '1;
        out_data_nxt.status = found_r ? ST_OK : ST_UNKNOWN;
      end
      OP_SETPAR: out_data_nxt.status = found_r ? ST_OK : ST_UNKNOWN;
      default:   out_data_nxt.found = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      def_par_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        def_par_r <= cfg_wdata;
      end
      if (cmd.start) begin
        rd_idx_r <= '0;
        wr_idx_r <= '0;
        pend_r   <= 1'b0;
        found_r  <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_idx_r <= rd_idx_r + CNT_W'(issue);
        pend_r   <= issue;
        if (key_hit) begin
          found_r <= 1'b1;
        end else if (pend_r) begin
          wr_idx_r <= wr_idx_r + CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_data;
    end
    if (cmd.scan_en) begin
      pend_idx_r <= rd_idx_r[IDX_W-1:0];
      if (key_hit && !found_r) begin
        hit_idx_r <= pend_idx_r;
        hit_id_r  <= rd_q.id;
        hit_par_r <= rd_q.par;
      end
    end
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/keyed_device_table.sv
// Top level of the keyed device table: controller, datapath and checks.
`timescale 1ns / 1ps

// Keyed device table. Holds up to TABLE_DEPTH entries (serial key, device id,
// parameter) packed into slots 0 .. count-1 in the order they were added, in
// a single-port-write RAM with registered read. Every item gives exactly one
// result item. Each item walks the live slots one per cycle through the RAM
// read port: it is accepted, the scan runs until the last read has been
// checked, and the result is committed; the next item is accepted only after
// that commit. Lookups act on the first matching slot; remove drops every
// match and compacts the survivors during the same walk, writing each one
// back to its new slot. The result sits in an output register, so a stalled
// consumer only holds up the commit of the following item.
// default_param is written through cfg_we / cfg_wdata and must only change
// while the block is idle.
module keyed_device_table import kdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  kdt_cmd_t cmd;
  kdt_sts_t sts;

  // Sequencing: idle, walk the table, then commit once the output is free
  kdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table storage, scan pointers and result register
  kdt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The live count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // One item at a time: no second acceptance straight after the first
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one in flight");

  // A commit always presents a result in the next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result");

  // Only a commit may change the count
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(sts.count))
    else $error("count changed outside commit");

endmodule

>>> tb/tb_keyed_device_table.sv
// Self-checking testbench for the keyed device table: random and directed ops.
`timescale 1ns / 1ps

module tb_keyed_device_table;
  import kdt_pkg::*;

  // Op codes the block decodes as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int IDLE_PCT       = 22;    // chance in a hundred that a side idles
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 40;    // > worst-case item time (full table)
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving
  localparam int POOL_SIZE      = 8;
  localparam int REPORT_MAX     = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  keyed_device_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. Live entries sit in slots 0 .. shadow_count-1 in
  // order of addition, exactly as the block keeps them.
  // ---------------------------------------------------------------------------
  logic [31:0] shadow_key [TABLE_DEPTH];
  logic [31:0] shadow_id  [TABLE_DEPTH];
  logic [31:0] shadow_par [TABLE_DEPTH];
  int          shadow_count = 0;
  logic [31:0] shadow_default = '0;

  out_item_t   expected_results[$];
  in_item_t    pending_items[$];

  int          sent_count = 0;    // items raised on in_valid
  int          taken_count = 0;   // items accepted by the block
  int          err_count = 0;
  int          stall_cycles = 0;

  bit          quiet = 1'b0;      // no idling on either side
  int          hold_req = 0;      // bumped to ask the receiver for a hold-off
  int          hold_done = 0;
  int          hold_left = 0;

  logic [31:0] key_pool [POOL_SIZE];

  // Apply one op to the shadow table and return the result it should produce.
  function automatic out_item_t table_apply(in_item_t it);
    int        hit;
    int        wr;
    out_item_t res;
    hit = -1;
    res = '0;
    res.status = ST_OK;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_key[i] == it.serial) hit = i;
    end
    case (it.op)
      OP_ADD: begin
        res.found = (hit >= 0);
        if (shadow_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_key[shadow_count] = it.serial;
          shadow_id[shadow_count]  = it.device_id;
          shadow_par[shadow_count] = shadow_default;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        // every match goes; survivors close up keeping their order
        wr = 0;
        for (int r = 0; r < shadow_count; r++) begin
          if (shadow_key[r] == it.serial) begin
            res.found = 1'b1;
          end else begin
            shadow_key[wr] = shadow_key[r];
            shadow_id[wr]  = shadow_id[r];
            shadow_par[wr] = shadow_par[r];
            wr++;
          end
        end
        shadow_count = wr;
      end
      OP_ISOPEN: begin
        res.found = (hit >= 0);
        res.value = {31'd0, res.found};
      end
      OP_GET: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.value = shadow_id[hit];
        end else begin
          res.value = '1;
        end
      end
      OP_GETPAR: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          res.value = shadow_par[hit];
        end else begin
          res.value  = '1;
          res.status = ST_UNKNOWN;
        end
      end
      OP_SETPAR: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          shadow_par[hit] = it.param_value;
        end else begin
          res.status = ST_UNKNOWN;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: changes on the falling edge. A new item goes up only once the last
  // one has been taken, so valid and payload hold steady while waiting.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (sent_count == taken_count) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_data    <= pending_items.pop_front();
        in_valid   <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // output register fills and the block stops taking items.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_req;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge, predicts on acceptance,
  // checks results in order, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(table_apply(in_data));
        taken_count <= taken_count + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("ERROR: result with none expected: found=%0d value=%h status=%0d",
                     out_data.found, out_data.value, out_data.status);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_data.found !== want.found || out_data.value !== want.value ||
              out_data.status !== want.status) begin
            err_count++;
            if (err_count <= REPORT_MAX) begin
              $display("ERROR: mismatch: expected found=%0d value=%h status=%0d",
                       want.found, want.value, want.status);
              $display("       got      found=%0d value=%h status=%0d",
                       out_data.found, out_data.value, out_data.status);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [2:0] op, logic [31:0] serial,
                           logic [31:0] dev, logic [31:0] par);
    in_item_t it;
    it.op          = op;
    it.serial      = serial;
    it.device_id   = dev;
    it.param_value = par;
    pending_items.push_back(it);
  endtask

  // Mostly random words, with the signed extremes mixed in
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  // Block must be idle: all items taken, every result back, then a margin.
  task automatic wait_idle();
    while (pending_items.size() != 0 || sent_count != taken_count ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default(logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_default = v;
  endtask

  // A burst of random ops over a small key pool, so lookups and removes hit.
  // add_w / rem_w set the percentage of adds and removes; a few percent are
  // spare op codes, the rest are lookups and parameter writes.
  task automatic random_burst(int n_items, int add_w, int rem_w);
    int          r;
    logic [2:0]  op;
    logic [31:0] serial;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < add_w)              op = OP_ADD;
      else if (r < add_w + rem_w) op = OP_REMOVE;
      else if (r < 97)            op = 3'($urandom_range(OP_SETPAR, OP_ISOPEN));
      else if (r < 98)            op = OP_SPARE_LO;
      else                        op = OP_SPARE_HI;
      serial = ($urandom_range(9) == 0) ? 32'($urandom)
                                        : key_pool[$urandom_range(POOL_SIZE - 1)];
      push_item(op, serial, pick_word(), pick_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table misses, spare codes, duplicate keys, parameter
    // round trip and a remove that takes out more than one entry.
    push_item(OP_GETPAR, 32'd5, 32'd0, 32'd0);
    push_item(OP_SETPAR, 32'd5, 32'd0, 32'd9);
    push_item(OP_GET,    32'd5, 32'd0, 32'd0);
    push_item(OP_ISOPEN, 32'd5, 32'd0, 32'd0);
    push_item(OP_REMOVE, 32'd5, 32'd0, 32'd0);
    push_item(OP_SPARE_LO, 32'd0, 32'd0, 32'd0);
    push_item(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(OP_ADD,    32'h0000_0000, 32'h8000_0000, 32'd0);
    push_item(OP_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    push_item(OP_ADD,    32'h0000_0000, 32'd1, 32'd0);         // duplicate key
    push_item(OP_ISOPEN, 32'h0000_0000, 32'd0, 32'd0);
    push_item(OP_GET,    32'h0000_0000, 32'd0, 32'd0);         // first match wins
    push_item(OP_GETPAR, 32'hFFFF_FFFF, 32'd0, 32'd0);         // reset default
    push_item(OP_SETPAR, 32'h0000_0000, 32'd0, 32'h7FFF_FFFF);
    push_item(OP_GETPAR, 32'h0000_0000, 32'd0, 32'd0);
    push_item(OP_SETPAR, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
    push_item(OP_GETPAR, 32'hFFFF_FFFF, 32'd0, 32'd0);
    push_item(OP_REMOVE, 32'h0000_0000, 32'd0, 32'd0);         // drops both
    push_item(OP_GET,    32'h0000_0000, 32'd0, 32'd0);
    push_item(OP_GET,    32'hFFFF_FFFF, 32'd0, 32'd0);
    push_item(OP_GETPAR, 32'hFFFF_FFFF, 32'd0, 32'd0);         // par moved down
    push_item(OP_REMOVE, 32'hFFFF_FFFF, 32'd0, 32'd0);
    wait_idle();

    // Add-heavy: fills the table and keeps knocking on it when full. The
    // receiver stalls for a long stretch while items are still on offer.
    write_default(32'h7FFF_FFFF);
    random_burst(160, 75, 3);
    @(posedge clk);
    hold_req = hold_req + 1;
    wait_idle();

    // Balanced mix with no idling on either side
    write_default(32'h8000_0000);
    quiet = 1'b1;
    random_burst(160, 35, 15);
    wait_idle();
    quiet = 1'b0;

    // Remove-heavy: table mostly near empty
    write_default(32'hFFFF_FFFF);
    random_burst(160, 20, 30);
    wait_idle();

    write_default($urandom);
    random_burst(160, 50, 10);
    wait_idle();

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
